// ----- rtl/core/bresenham_line_rasterizer_defines.svh -----
// Assertion macros shared by the line rasterizer RTL.
// Depends on nothing; files that check take it by include.
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BLR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line rasterizer check failed");

// Next-cycle implication, disabled while reset is high.
`define BLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line rasterizer check failed");

`endif

// ----- rtl/core/blr_pkg.sv -----
// Shared types, constants and helper functions of the line rasterizer.
// Depends on nothing; every RTL file of the block uses it.
package blr_pkg;

   localparam int COORD_BITS = 12;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int COLOR_BITS = 32;

   localparam logic [COLOR_BITS-1:0] COLOR_RESET = 32'hff00_0000;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic        [COORD_BITS-1:0] mag_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic        [COLOR_BITS-1:0] color_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   // Octants counted counter-clockwise from +x with y pointing down.
   typedef enum logic [2:0] {
      OCT_ONE   = 3'd0,
      OCT_TWO   = 3'd1,
      OCT_THREE = 3'd2,
      OCT_FOUR  = 3'd3,
      OCT_FIVE  = 3'd4,
      OCT_SIX   = 3'd5,
      OCT_SEVEN = 3'd6,
      OCT_EIGHT = 3'd7
   } oct_type;

   typedef struct packed {
      cmd_type   command;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic      pixel_valid;
      coord_type pixel_x;
      coord_type pixel_y;
      color_type pixel_color;
      logic      last_pixel;
   } rsp_type;

   // Line setup derived from a start word.
   typedef struct packed {
      oct_type   octant;
      delta_type delta_x;
      delta_type delta_y;
      coord_type major_end;
   } setup_type;

   function automatic mag_type delta_mag(input delta_type d);
      delta_type neg;
      neg = -d;
      return d[DELTA_BITS-1] ? neg[COORD_BITS-1:0] : d[COORD_BITS-1:0];
   endfunction

   function automatic logic is_x_major(input oct_type o);
      return (o == OCT_ONE) || (o == OCT_FOUR) || (o == OCT_FIVE) || (o == OCT_EIGHT);
   endfunction

endpackage

// ----- rtl/core/blr_setup.sv -----
// Start-word decode: endpoint deltas, octant and major-axis endpoint.
// Depends on blr_pkg.
module blr_setup (
   input  blr_pkg::req_type   req,
   output blr_pkg::setup_type setup
);

   blr_pkg::delta_type dx;
   blr_pkg::delta_type dy;
   blr_pkg::mag_type   adx;
   blr_pkg::mag_type   ady;
   logic               x_major;

   assign dx = {req.end_x[blr_pkg::COORD_BITS-1], req.end_x}
             - {req.start_x[blr_pkg::COORD_BITS-1], req.start_x};
   assign dy = {req.end_y[blr_pkg::COORD_BITS-1], req.end_y}
             - {req.start_y[blr_pkg::COORD_BITS-1], req.start_y};
   assign adx = blr_pkg::delta_mag(dx);
   assign ady = blr_pkg::delta_mag(dy);

   // Lines at exactly 45 degrees fall to the x-major side.
   assign x_major = (ady <= adx);

   always_comb begin
      setup.delta_x = dx;
      setup.delta_y = dy;
      if (x_major) begin
         setup.major_end = req.end_x;
         if (!dx[blr_pkg::DELTA_BITS-1]) begin
            setup.octant = (dy <= 0) ? blr_pkg::OCT_ONE : blr_pkg::OCT_EIGHT;
         end else begin
            setup.octant = (dy <= 0) ? blr_pkg::OCT_FOUR : blr_pkg::OCT_FIVE;
         end
      end else begin
         setup.major_end = req.end_y;
         if (dy[blr_pkg::DELTA_BITS-1]) begin
            setup.octant = dx[blr_pkg::DELTA_BITS-1] ? blr_pkg::OCT_THREE
                                                      : blr_pkg::OCT_TWO;
         end else begin
            setup.octant = dx[blr_pkg::DELTA_BITS-1] ? blr_pkg::OCT_SIX
                                                      : blr_pkg::OCT_SEVEN;
         end
      end
   end

endmodule

// ----- rtl/core/blr_core.sv -----
// Line state registers and the one-pixel Bresenham step.
// Depends on blr_pkg; the setup struct comes from blr_setup.
module blr_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  blr_pkg::req_type   req,
   input  blr_pkg::setup_type setup,
   input  blr_pkg::color_type draw_color,
   output blr_pkg::rsp_type   rsp,
   output logic               active
);

   blr_pkg::coord_type cur_x_ff, cur_x_in;
   blr_pkg::coord_type cur_y_ff, cur_y_in;
   blr_pkg::coord_type major_end_ff, major_end_in;
   blr_pkg::delta_type delta_x_ff, delta_x_in;
   blr_pkg::delta_type delta_y_ff, delta_y_in;
   blr_pkg::err_type   error_ff, error_in;
   blr_pkg::oct_type   octant_ff, octant_in;
   logic               active_ff, active_in;

   logic                      is_start;
   logic                      xm;
   blr_pkg::mag_type          dmaj;
   blr_pkg::mag_type          dmin;
   blr_pkg::err_type          err_sum;
   logic signed [blr_pkg::ERR_BITS:0] err_twice;
   logic signed [blr_pkg::ERR_BITS:0] dmaj_ext;
   logic                      minor_step;
   blr_pkg::err_type          err_next;
   blr_pkg::coord_type        step_x;
   blr_pkg::coord_type        step_y;
   blr_pkg::coord_type        next_x;
   blr_pkg::coord_type        next_y;
   logic                      start_last;
   logic                      step_last;

   assign is_start = (req.command == blr_pkg::CMD_START);

   // Step datapath, working on the registered line state.
   assign xm   = blr_pkg::is_x_major(octant_ff);
   assign dmaj = xm ? blr_pkg::delta_mag(delta_x_ff) : blr_pkg::delta_mag(delta_y_ff);
   assign dmin = xm ? blr_pkg::delta_mag(delta_y_ff) : blr_pkg::delta_mag(delta_x_ff);

   assign err_sum    = error_ff + blr_pkg::err_type'(dmin);
   assign err_twice  = {err_sum, 1'b0};
   assign dmaj_ext   = (blr_pkg::ERR_BITS+1)'(dmaj);
   // The minor axis moves when twice the error reaches the major delta.
   assign minor_step = !(err_twice < dmaj_ext);
   assign err_next   = minor_step ? err_sum - blr_pkg::err_type'(dmaj) : err_sum;

   assign step_x = delta_x_ff[blr_pkg::DELTA_BITS-1] ? '1 : blr_pkg::coord_type'(1);
   assign step_y = delta_y_ff[blr_pkg::DELTA_BITS-1] ? '1 : blr_pkg::coord_type'(1);
   assign next_x = (xm || minor_step) ? cur_x_ff + step_x : cur_x_ff;
   assign next_y = (!xm || minor_step) ? cur_y_ff + step_y : cur_y_ff;

   assign step_last  = xm ? (next_x == major_end_ff) : (next_y == major_end_ff);
   assign start_last = blr_pkg::is_x_major(setup.octant) ? (req.start_x == setup.major_end)
                                                        : (req.start_y == setup.major_end);

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      major_end_in = major_end_ff;
      delta_x_in   = delta_x_ff;
      delta_y_in   = delta_y_ff;
      error_in     = error_ff;
      octant_in    = octant_ff;
      active_in    = active_ff;
      rsp          = '0;
      if (is_start) begin
         cur_x_in        = req.start_x;
         cur_y_in        = req.start_y;
         major_end_in    = setup.major_end;
         delta_x_in      = setup.delta_x;
         delta_y_in      = setup.delta_y;
         error_in        = '0;
         octant_in       = setup.octant;
         active_in       = !start_last;
         rsp.pixel_valid = 1'b1;
         rsp.pixel_x     = req.start_x;
         rsp.pixel_y     = req.start_y;
         rsp.pixel_color = draw_color;
         rsp.last_pixel  = start_last;
      end else if (active_ff) begin
         cur_x_in        = next_x;
         cur_y_in        = next_y;
         error_in        = err_next;
         active_in       = !step_last;
         rsp.pixel_valid = 1'b1;
         rsp.pixel_x     = next_x;
         rsp.pixel_y     = next_y;
         rsp.pixel_color = draw_color;
         rsp.last_pixel  = step_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (fire) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         major_end_ff <= major_end_in;
         delta_x_ff   <= delta_x_in;
         delta_y_ff   <= delta_y_in;
         error_ff     <= error_in;
         octant_ff    <= octant_in;
      end
   end

   assign active = active_ff;

endmodule

// ----- rtl/core/bresenham_line_rasterizer.sv -----
// Bresenham line rasterizer, all eight octants, one result word per request word.
// An accepted word waits in the input register; its result is registered in the output word register behind rsp_.
// Throughput: one word per cycle while rsp_stall is low; the line state feeds back through a single step.
// Reset (synchronous, active high) idles the line, empties both word registers and
// sets the draw color to opaque black.
module bresenham_line_rasterizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  blr_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output blr_pkg::rsp_type   rsp_data,
   input  logic               csr_wr_en,
   input  blr_pkg::color_type csr_wr_data
);

`include "bresenham_line_rasterizer_defines.svh"

   logic               in_vld_ff, in_vld_in;
   blr_pkg::req_type   in_word_ff;
   logic               out_vld_ff, out_vld_in;
   blr_pkg::rsp_type   out_word_ff;
   blr_pkg::color_type color_ff;

   logic               out_free;
   logic               fire;
   logic               req_take;
   blr_pkg::setup_type setup;
   blr_pkg::rsp_type   core_rsp;
   logic               core_active;

   // The input register moves into the result register whenever that one
   // is empty or being drained in the same cycle.
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_vld_in  = req_take || (in_vld_ff && !fire);
   assign out_vld_in = fire || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         color_ff   <= blr_pkg::COLOR_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_data;
      end
      if (fire) begin
         out_word_ff <= core_rsp;
      end
   end

   blr_setup u_setup (
      .req   (in_word_ff),
      .setup (setup)
   );

   blr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .req        (in_word_ff),
      .setup      (setup),
      .draw_color (color_ff),
      .rsp        (core_rsp),
      .active     (core_active)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_word_ff;

   `BLR_ASSERT_NEXT(a_fire_gives_word, clock, reset, fire, rsp_valid)
   `BLR_ASSERT_NEXT(a_last_goes_idle, clock, reset, fire && core_rsp.last_pixel, !core_active)
   `BLR_ASSERT_NEXT(a_idle_step_empty, clock, reset,
      fire && (in_word_ff.command == blr_pkg::CMD_STEP) && !core_active,
      rsp_valid && !rsp_data.pixel_valid && (rsp_data.pixel_color == '0))
   `BLR_ASSERT_NOW(a_start_emits, clock, reset,
      fire && (in_word_ff.command == blr_pkg::CMD_START), core_rsp.pixel_valid)

endmodule
